// ===== hw/rtl/unv_pkg.sv =====
// Shared types and constants for the UTF-8 name validator.
package unv_pkg;

	localparam int unsigned CapacityDefault = 64;

	localparam int unsigned CpWidth = 21;

	// Sequence length class of an open multi-byte sequence.
	localparam logic [1:0] ClsNone  = 2'd0;
	localparam logic [1:0] ClsTwo   = 2'd1;
	localparam logic [1:0] ClsThree = 2'd2;
	localparam logic [1:0] ClsFour  = 2'd3;

	localparam logic [CpWidth-1:0] CpMax      = 21'h10ffff;
	localparam logic [CpWidth-1:0] CpSurrLo   = 21'h00d800;
	localparam logic [CpWidth-1:0] CpSurrHi   = 21'h00dfff;
	localparam logic [CpWidth-1:0] CpSpace    = 21'h000020;
	localparam logic [CpWidth-1:0] CpDel      = 21'h00007f;
	localparam logic [CpWidth-1:0] CpC1Hi     = 21'h00009f;
	localparam logic [CpWidth-1:0] CpMinTwo   = 21'h000080;
	localparam logic [CpWidth-1:0] CpMinThree = 21'h000800;
	localparam logic [CpWidth-1:0] CpMinFour  = 21'h010000;

	// Decoder state carried from byte to byte within one name.
	typedef struct packed {
		logic [1:0]         pending;
		logic [CpWidth-1:0] cp;
		logic [1:0]         cls;
		logic               err;
	} dec_state_t;

endpackage

// ===== hw/rtl/unv_decode.sv =====
// Next-state logic for one nonzero byte of a UTF-8 name.
module unv_decode (
	input  logic [7:0]              char_byte,
	input  unv_pkg::dec_state_t     cur,
	output unv_pkg::dec_state_t     nxt
);

	logic [unv_pkg::CpWidth-1:0] cp_cont;
	logic [unv_pkg::CpWidth-1:0] cp_ascii;
	logic [unv_pkg::CpWidth-1:0] cp_min;
	logic [1:0]                  pend_dec;
	logic                        ascii_bad;
	logic                        seq_bad;

	assign cp_cont  = {cur.cp[unv_pkg::CpWidth-7:0], char_byte[5:0]};
	assign cp_ascii = {{(unv_pkg::CpWidth-8){1'b0}}, char_byte};
	assign pend_dec = cur.pending - 2'd1;

	always_comb begin
		unique case (cur.cls)
			unv_pkg::ClsTwo:   cp_min = unv_pkg::CpMinTwo;
			unv_pkg::ClsThree: cp_min = unv_pkg::CpMinThree;
			unv_pkg::ClsFour:  cp_min = unv_pkg::CpMinFour;
			default:           cp_min = '0;
		endcase
	end

	// Single-byte characters: reject C0 controls and DEL.
	assign ascii_bad = (cp_ascii < unv_pkg::CpSpace) || (cp_ascii == unv_pkg::CpDel);

	assign seq_bad = (cp_cont < cp_min) || (cp_cont > unv_pkg::CpMax) ||
		((cp_cont >= unv_pkg::CpSurrLo) && (cp_cont <= unv_pkg::CpSurrHi)) ||
		(cp_cont < unv_pkg::CpSpace) ||
		((cp_cont >= unv_pkg::CpDel) && (cp_cont <= unv_pkg::CpC1Hi));

	always_comb begin
		nxt = cur;
		if (!cur.err) begin
			if (cur.pending == 2'd0) begin
				priority casez (char_byte)
					8'b0???????: nxt.err = ascii_bad;
					8'b110?????: begin
						nxt.cp      = {{(unv_pkg::CpWidth-5){1'b0}}, char_byte[4:0]};
						nxt.pending = 2'd1;
						nxt.cls     = unv_pkg::ClsTwo;
					end
					8'b1110????: begin
						nxt.cp      = {{(unv_pkg::CpWidth-4){1'b0}}, char_byte[3:0]};
						nxt.pending = 2'd2;
						nxt.cls     = unv_pkg::ClsThree;
					end
					8'b11110???: begin
						nxt.cp      = {{(unv_pkg::CpWidth-3){1'b0}}, char_byte[2:0]};
						nxt.pending = 2'd3;
						nxt.cls     = unv_pkg::ClsFour;
					end
					default: nxt.err = 1'b1;
				endcase
			end else if (char_byte[7:6] != 2'b10) begin
				// Drop the open sequence on a broken continuation.
				nxt.err     = 1'b1;
				nxt.pending = 2'd0;
			end else begin
				nxt.pending = pend_dec;
				if (pend_dec == 2'd0) begin
					nxt.err = seq_bad;
					nxt.cp  = '0;
					nxt.cls = unv_pkg::ClsNone;
				end else begin
					nxt.cp = cp_cont;
				end
			end
		end
	end

endmodule

// ===== hw/rtl/utf8_name_validator_core.sv =====
// Top level of the UTF-8 name validator: input register, decoder and result register.
// Takes a zero-terminated name one byte per transaction and gives one verdict
// per name on name_ok: 1 for well-formed UTF-8 of one to four byte sequences,
// free of overlong forms, surrogates, code points above 0x10FFFF and C0, DEL
// and C1 controls; 0 otherwise, for an empty name, or when CAPACITY nonzero
// bytes arrive without a terminator (that verdict is given on the CAPACITY-th
// byte and a new name starts). One byte is accepted every cycle; the verdict
// is registered, set by the input register and the result register around
// the combinational decoder. Input stalls only when a byte that ends a name
// meets a full result register not being drained.
module utf8_name_validator_core #(
	parameter int unsigned CAPACITY = unv_pkg::CapacityDefault
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       name_ok
);

	localparam int unsigned CntW = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;

	logic                valid_s1;
	logic [7:0]          byte_s1;
	logic [CntW-1:0]     byte_count_q;
	unv_pkg::dec_state_t state_q;
	unv_pkg::dec_state_t dec_nxt;
	logic                out_valid_q;
	logic                name_ok_q;

	logic is_term;
	logic at_limit;
	logic emit;
	logic verdict;
	logic out_free;
	logic adv_s1;

	unv_decode u_decode (
		.char_byte (byte_s1),
		.cur       (state_q),
		.nxt       (dec_nxt)
	);

	assign is_term  = (byte_s1 == 8'd0);
	assign at_limit = (byte_count_q == CntW'(CAPACITY - 1));
	assign emit     = is_term || at_limit;
	assign verdict  = is_term && (byte_count_q != '0) && !state_q.err &&
		(state_q.pending == 2'd0);
	assign out_free = !out_valid_q || out_ready;
	assign adv_s1   = valid_s1 && (!emit || out_free);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= char_byte;
		end
	end

	// Advance the name state; clear it whenever a verdict leaves.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			state_q      <= '0;
		end else if (adv_s1) begin
			if (emit) begin
				byte_count_q <= '0;
				state_q      <= '0;
			end else begin
				byte_count_q <= byte_count_q + CntW'(1);
				state_q      <= dec_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && emit) begin
			name_ok_q <= verdict;
		end
	end

	assign out_valid = out_valid_q;
	assign name_ok   = name_ok_q;

`ifndef SYNTHESIS
	a_clear_after_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && emit |=> (byte_count_q == '0) && !state_q.err &&
			(state_q.pending == 2'd0))
		else $error("name state not cleared after verdict");

	a_limit_rejects: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && at_limit && !is_term |=> out_valid_q && !name_ok_q)
		else $error("capacity verdict not invalid");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		byte_count_q <= CntW'(CAPACITY - 1))
		else $error("byte count beyond capacity");

	a_pending_class: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.pending != 2'd0 |-> (state_q.cls != unv_pkg::ClsNone) &&
			(state_q.pending <= state_q.cls))
		else $error("pending count disagrees with sequence class");
`endif

endmodule

// ===== dv/utf8_name_validator_core_tb.sv =====
// Self-checking testbench for the UTF-8 name validator core.
`timescale 1ns / 100ps

module utf8_name_validator_core_tb;

	localparam int unsigned Cap = unv_pkg::CapacityDefault;

	typedef logic [7:0] byte_q_t[$];
	typedef logic [unv_pkg::CpWidth-1:0] cp_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] char_byte;
	logic       out_valid;
	logic       out_ready;
	logic       name_ok;

	// Verdicts the block owes, oldest first
	logic verdicts_due[$];

	// Predicted decoder state of the current name
	int unsigned name_len;
	logic [1:0]  seq_left;
	cp_t         cp_acc;
	logic [1:0]  seq_cls;
	bit          name_bad;

	byte_q_t     name_buf;
	bit          no_gaps;
	int unsigned sent_bytes;
	int unsigned names_sent;
	int unsigned verdicts_seen;
	int unsigned ok_verdicts;
	int unsigned err_count;

	utf8_name_validator_core #(
		.CAPACITY(Cap)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.char_byte(char_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.name_ok  (name_ok)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic bit cp_forbidden(input cp_t cp, input logic [1:0] cls);
		cp_t floor_cp;
		case (cls)
			unv_pkg::ClsTwo: begin
				floor_cp = unv_pkg::CpMinTwo;
			end
			unv_pkg::ClsThree: begin
				floor_cp = unv_pkg::CpMinThree;
			end
			unv_pkg::ClsFour: begin
				floor_cp = unv_pkg::CpMinFour;
			end
			default: begin
				floor_cp = '0;
			end
		endcase
		return cp < floor_cp || cp > unv_pkg::CpMax ||
			(cp >= unv_pkg::CpSurrLo && cp <= unv_pkg::CpSurrHi) ||
			cp < unv_pkg::CpSpace || (cp >= unv_pkg::CpDel && cp <= unv_pkg::CpC1Hi);
	endfunction

	task automatic clear_name();
		name_len = 0;
		seq_left = '0;
		cp_acc   = '0;
		seq_cls  = unv_pkg::ClsNone;
		name_bad = 1'b0;
	endtask

	task automatic decode_byte(input logic [7:0] b);
		if (name_bad)
			return;
		if (seq_left == 2'd0) begin
			if (b[7] == 1'b0) begin
				if (cp_forbidden({13'd0, b}, unv_pkg::ClsNone))
					name_bad = 1'b1;
			end else if (b[7:5] == 3'b110) begin
				cp_acc   = {16'd0, b[4:0]};
				seq_left = 2'd1;
				seq_cls  = unv_pkg::ClsTwo;
			end else if (b[7:4] == 4'b1110) begin
				cp_acc   = {17'd0, b[3:0]};
				seq_left = 2'd2;
				seq_cls  = unv_pkg::ClsThree;
			end else if (b[7:3] == 5'b11110) begin
				cp_acc   = {18'd0, b[2:0]};
				seq_left = 2'd3;
				seq_cls  = unv_pkg::ClsFour;
			end else begin
				name_bad = 1'b1;
			end
			return;
		end
		if (b[7:6] != 2'b10) begin
			name_bad = 1'b1;
			seq_left = 2'd0;
			return;
		end
		cp_acc   = {cp_acc[unv_pkg::CpWidth-7:0], b[5:0]};
		seq_left = seq_left - 2'd1;
		if (seq_left == 2'd0) begin
			if (cp_forbidden(cp_acc, seq_cls))
				name_bad = 1'b1;
			cp_acc  = '0;
			seq_cls = unv_pkg::ClsNone;
		end
	endtask

	// Advance the predicted state by one accepted byte; queue any verdict it causes
	task automatic track_byte(input logic [7:0] b);
		if (b == 8'h00) begin
			verdicts_due.push_back(name_len != 0 && !name_bad && seq_left == 2'd0);
			clear_name();
			return;
		end
		decode_byte(b);
		name_len++;
		if (name_len >= Cap) begin
			verdicts_due.push_back(1'b0);
			clear_name();
		end
	endtask

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $time, what);
		err_count++;
	endtask

	task automatic send_byte(input logic [7:0] b);
		int unsigned gap;
		gap = no_gaps ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		char_byte <= b;
		do
			@(posedge clk);
		while (!in_ready);
		track_byte(b);
		sent_bytes++;
		if (b == 8'h00)
			names_sent++;
	endtask

	task automatic send_name();
		foreach (name_buf[i])
			send_byte(name_buf[i]);
		send_byte(8'h00);
	endtask

	// Hold the input until every owed verdict has arrived, then let the pipeline settle
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (verdicts_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic append_cp(input cp_t cp);
		if (cp < unv_pkg::CpMinTwo) begin
			name_buf.push_back(cp[7:0]);
		end else if (cp < unv_pkg::CpMinThree) begin
			name_buf.push_back({3'b110, cp[10:6]});
			name_buf.push_back({2'b10, cp[5:0]});
		end else if (cp < unv_pkg::CpMinFour) begin
			name_buf.push_back({4'b1110, cp[15:12]});
			name_buf.push_back({2'b10, cp[11:6]});
			name_buf.push_back({2'b10, cp[5:0]});
		end else begin
			name_buf.push_back({5'b11110, cp[20:18]});
			name_buf.push_back({2'b10, cp[17:12]});
			name_buf.push_back({2'b10, cp[11:6]});
			name_buf.push_back({2'b10, cp[5:0]});
		end
	endtask

	// Fill the buffer with n legal characters, boundaries of each length now and then
	task automatic build_clean(input int unsigned n);
		cp_t cp;
		cp_t lo;
		cp_t hi;
		name_buf.delete();
		repeat (n) begin
			case ($urandom_range(0, 3))
				0: begin
					lo = unv_pkg::CpSpace;
					hi = unv_pkg::CpDel - cp_t'(1);
				end
				1: begin
					lo = unv_pkg::CpC1Hi + cp_t'(1);
					hi = unv_pkg::CpMinThree - cp_t'(1);
				end
				2: begin
					lo = unv_pkg::CpMinThree;
					hi = unv_pkg::CpMinFour - cp_t'(1);
				end
				default: begin
					lo = unv_pkg::CpMinFour;
					hi = unv_pkg::CpMax;
				end
			endcase
			case ($urandom_range(0, 7))
				0: cp = lo;
				1: cp = hi;
				default: cp = cp_t'($urandom_range(lo, hi));
			endcase
			// steer clear of the surrogate block
			if (cp >= unv_pkg::CpSurrLo && cp <= unv_pkg::CpSurrHi)
				cp = cp ^ 21'h008000;
			append_cp(cp);
		end
	endtask

	task automatic test_directed();
		name_buf = {};
		send_name();
		name_buf = '{8'h41};
		send_name();
		name_buf = '{8'h20, 8'h7e};
		send_name();
		name_buf = '{8'h1f};
		send_name();
		name_buf = '{8'h01};
		send_name();
		name_buf = '{8'h7f};
		send_name();
		// C1 controls and their edges
		name_buf = '{8'hc2, 8'h80};
		send_name();
		name_buf = '{8'hc2, 8'h9f};
		send_name();
		name_buf = '{8'hc2, 8'ha0, 8'hdf, 8'hbf};
		send_name();
		// overlong forms
		name_buf = '{8'hc0, 8'h80};
		send_name();
		name_buf = '{8'hc1, 8'hbf};
		send_name();
		name_buf = '{8'he0, 8'h9f, 8'hbf};
		send_name();
		name_buf = '{8'he0, 8'ha0, 8'h80};
		send_name();
		name_buf = '{8'hf0, 8'h8f, 8'hbf, 8'hbf};
		send_name();
		// surrogates and their neighbours
		name_buf = '{8'hed, 8'ha0, 8'h80};
		send_name();
		name_buf = '{8'hed, 8'hbf, 8'hbf};
		send_name();
		name_buf = '{8'hed, 8'h9f, 8'hbf, 8'hee, 8'h80, 8'h80};
		send_name();
		// top of the code space
		name_buf = '{8'hf0, 8'h90, 8'h80, 8'h80, 8'hf4, 8'h8f, 8'hbf, 8'hbf};
		send_name();
		name_buf = '{8'hf4, 8'h90, 8'h80, 8'h80};
		send_name();
		name_buf = '{8'hf7, 8'hbf, 8'hbf, 8'hbf};
		send_name();
		// bad lead bytes, bad continuation, cut-off sequence
		name_buf = '{8'h80, 8'h41};
		send_name();
		name_buf = '{8'hf8, 8'h41};
		send_name();
		name_buf = '{8'hff};
		send_name();
		name_buf = '{8'hc3, 8'h41, 8'hc3, 8'ha9};
		send_name();
		name_buf = '{8'he2, 8'h82};
		send_name();
		// longest legal name, then one that hits capacity and leaves an empty name behind
		name_buf.delete();
		repeat (Cap - 1) name_buf.push_back(8'h61);
		send_name();
		name_buf.delete();
		repeat (Cap) name_buf.push_back(8'h62);
		send_name();
	endtask

	task automatic test_drain_pause();
		build_clean(3);
		send_name();
		wait_drained();
		build_clean(2);
		send_name();
	endtask

	task automatic test_back_to_back();
		no_gaps = 1'b1;
		repeat (20) begin
			build_clean($urandom_range(1, 6));
			send_name();
		end
		no_gaps = 1'b0;
	endtask

	task automatic test_random_names(input int unsigned target);
		int unsigned pos;
		int unsigned n;
		while (sent_bytes < target) begin
			case ($urandom_range(0, 9))
				6, 7: begin
					// legal name with at most one fault: a random byte put in or a cut-off tail
					build_clean($urandom_range(1, 10));
					pos = $urandom_range(0, name_buf.size() - 1);
					if ($urandom_range(0, 1) == 0)
						name_buf[pos] = 8'($urandom_range(1, 255));
					else
						name_buf.delete(name_buf.size() - 1);
					send_name();
				end
				8: begin
					// raw noise, zeros included
					n = $urandom_range(1, 20);
					repeat (n) send_byte(8'($urandom_range(0, 255)));
				end
				9: begin
					// long names that may run into capacity mid-sequence
					build_clean($urandom_range(15, 30));
					send_name();
				end
				default: begin
					build_clean($urandom_range(1, 12));
					send_name();
				end
			endcase
			if ($urandom_range(0, 99) == 0)
				wait_drained();
		end
	endtask

	// Receiver: random back-pressure, compare each verdict with the oldest owed one
	initial begin
		int unsigned stall;
		logic        want;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = no_gaps ? 0 : $urandom_range(0, 12);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do
				@(posedge clk);
			while (!out_valid);
			verdicts_seen++;
			if (name_ok === 1'b1)
				ok_verdicts++;
			if (verdicts_due.size() == 0) begin
				report_mismatch($sformatf("unexpected verdict name_ok=%b", name_ok));
			end else begin
				want = verdicts_due.pop_front();
				if (name_ok !== want)
					report_mismatch($sformatf("name_ok=%b, predicted %b", name_ok, want));
			end
		end
	end

	initial begin
		#4ms;
		$display("timeout with %0d verdicts outstanding", verdicts_due.size());
		$display("FAIL utf8_name_validator_core");
		$finish;
	end

	initial begin
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		char_byte  = 8'h00;
		no_gaps    = 1'b0;
		sent_bytes = 0;
		names_sent = 0;
		verdicts_seen = 0;
		ok_verdicts   = 0;
		err_count     = 0;
		clear_name();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_drain_pause();
		test_back_to_back();
		test_random_names(1250);

		wait_drained();
		repeat (6) @(posedge clk);
		$display("covered %0d bytes in %0d terminated names; %0d verdicts checked, %0d valid",
			sent_bytes, names_sent, verdicts_seen, ok_verdicts);
		$display("%0d mismatches", err_count);
		if (err_count == 0 && verdicts_due.size() == 0) begin
			$display("PASS utf8_name_validator_core");
		end else begin
			$display("FAIL utf8_name_validator_core");
		end
		$finish;
	end

endmodule
